// ----- design/omps_pkg.sv -----
// shared constants and types for the occlusion mask pair score block
package omps_pkg;

  localparam int Patterns   = 16;
  localparam int MaskHeight = 64;
  localparam int MaskWidth  = 64;

  localparam int IdxW  = $clog2(Patterns);
  localparam int RowW  = $clog2(MaskHeight);
  localparam int ColW  = $clog2(MaskWidth);
  localparam int MaddrW = IdxW + RowW + ColW;

  localparam logic [1:0] REQ_BOX   = 2'd0;
  localparam logic [1:0] REQ_PIXEL = 2'd1;
  localparam logic [1:0] REQ_QUERY = 2'd2;

  localparam logic [1:0] PIX_EMPTY    = 2'd0;
  localparam logic [1:0] PIX_VISIBLE  = 2'd1;
  localparam logic [1:0] PIX_OCCLUDED = 2'd2;

  localparam logic [12:0] COUNT_MAX = 13'd8191;

  typedef struct packed {
    logic [6:0] left;
    logic [6:0] top;
    logic [6:0] right;
    logic [6:0] bottom;
  } box_t;

endpackage

// ----- design/occlusion_mask_pair_score_top.sv -----
// occlusion mask pair score: box and mask stores, union-box walk and serial divider
//
//  channel | ports                                         | handshake
//  input   | in_req_type .. in_pixel_value                 | start && !busy
//  result  | out_score, out_overlap_count, out_occluded... | out_valid, one cycle
//
// box load, pixel write and request type 3 give no result, busy stays low.
// query with equal indices: result in the cycle after the accept edge, busy stays low.
// disjoint boxes: busy for one cycle, result in the cycle after.
// otherwise busy through a walk of the union box in one-based coordinates
// (edge 0 and edges past the mask are walked too, up to 128 x 128): one pixel per cycle
// from both mask copies, then a restoring divider; result right after busy falls.
// reset is synchronous; stores are not cleared. the receiver cannot stall.
module occlusion_mask_pair_score_top (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  output logic        busy,
  input  logic [1:0]  in_req_type,
  input  logic [3:0]  in_first_index,
  input  logic [3:0]  in_second_index,
  input  logic [6:0]  in_box_left,
  input  logic [6:0]  in_box_top,
  input  logic [6:0]  in_box_right,
  input  logic [6:0]  in_box_bottom,
  input  logic [5:0]  in_pixel_column,
  input  logic [5:0]  in_pixel_row,
  input  logic [7:0]  in_pixel_value,
  output logic        out_valid,
  output logic [16:0] out_score,
  output logic [12:0] out_overlap_count,
  output logic [12:0] out_occluded_count,
  output logic        out_boxes_intersect
);
  import omps_pkg::*;

  localparam logic [2:0] ST_IDLE = 3'd0;
  localparam logic [2:0] ST_BOX  = 3'd1;  // box read data arriving
  localparam logic [2:0] ST_GEOM = 3'd2;
  localparam logic [2:0] ST_WALK = 3'd3;
  localparam logic [2:0] ST_DRAIN = 3'd4;
  localparam logic [2:0] ST_DIV  = 3'd5;
  localparam logic [2:0] ST_LOAD = 3'd6;

  box_t       box_mem [Patterns];
  logic [1:0] mask_a  [Patterns*MaskHeight*MaskWidth];
  logic [1:0] mask_b  [Patterns*MaskHeight*MaskWidth];

  logic [2:0]  state_r, state_nxt;
  logic [3:0]  idx_i_r, idx_j_r;
  box_t        bi_r, bj_r;
  logic [6:0]  x_r, y_r, xmin_r, xmax_r, ymax_r;
  logic        rd_v_r, rd_in_r, walk_last_r;
  logic [1:0]  pa_r, pb_r;
  logic [12:0] ovl_r, oi_r, oj_r;
  logic        inter_r;
  logic [4:0]  div_cnt_r;
  logic [16:0] num_r;
  logic [13:0] rem_r;
  logic [16:0] quo_r;
  logic        out_valid_r;

  logic accept;
  assign accept = start && !busy;
  assign busy   = (state_r != ST_IDLE);

  // writes, both mask copies mirror each other
  logic        px_ok;
  logic [1:0]  px_code;
  logic [MaddrW-1:0] wr_addr;
  assign px_ok   = ({1'b0, in_pixel_column} < 7'(MaskWidth)) &&
                   ({1'b0, in_pixel_row} < 7'(MaskHeight));
  assign px_code = (in_pixel_value == 8'd0) ? PIX_EMPTY :
                   (in_pixel_value == 8'd2) ? PIX_OCCLUDED : PIX_VISIBLE;
  assign wr_addr = {in_first_index[IdxW-1:0], in_pixel_row[RowW-1:0], in_pixel_column[ColW-1:0]};

  always_ff @(posedge clk) begin
    if (accept && in_req_type == REQ_BOX)
      box_mem[in_first_index] <= '{in_box_left, in_box_top, in_box_right, in_box_bottom};
    if (accept && in_req_type == REQ_PIXEL && px_ok) begin
      mask_a[wr_addr] <= px_code;
      mask_b[wr_addr] <= px_code;
    end
  end

  // box reads at query start
  logic [3:0] qi, qj;
  assign qi = (in_first_index < in_second_index) ? in_first_index : in_second_index;
  assign qj = (in_first_index < in_second_index) ? in_second_index : in_first_index;
  always_ff @(posedge clk) begin
    if (accept) begin
      bi_r <= box_mem[qi];
      bj_r <= box_mem[qj];
    end
  end

  // geometry
  logic [6:0] ux_l, ux_r, uy_t, uy_b, ix_l, ix_r, iy_t, iy_b;
  assign ix_l = (bi_r.left > bj_r.left) ? bi_r.left : bj_r.left;
  assign ix_r = (bi_r.right < bj_r.right) ? bi_r.right : bj_r.right;
  assign iy_t = (bi_r.top > bj_r.top) ? bi_r.top : bj_r.top;
  assign iy_b = (bi_r.bottom < bj_r.bottom) ? bi_r.bottom : bj_r.bottom;
  assign ux_l = (bi_r.left < bj_r.left) ? bi_r.left : bj_r.left;
  assign ux_r = (bi_r.right > bj_r.right) ? bi_r.right : bj_r.right;
  assign uy_t = (bi_r.top < bj_r.top) ? bi_r.top : bj_r.top;
  assign uy_b = (bi_r.bottom > bj_r.bottom) ? bi_r.bottom : bj_r.bottom;

  // walk addresses: one-based coordinate x reads column x-1
  logic [6:0] col0, row0;
  logic       in_mask;
  assign col0 = x_r - 7'd1;
  assign row0 = y_r - 7'd1;
  assign in_mask = (x_r != 7'd0) && (y_r != 7'd0) &&
                   (col0 < 7'(MaskWidth)) && (row0 < 7'(MaskHeight));
  logic walk_rd;
  assign walk_rd = (state_r == ST_WALK);

  always_ff @(posedge clk) begin
    if (walk_rd) begin
      pa_r <= mask_a[{idx_i_r[IdxW-1:0], row0[RowW-1:0], col0[ColW-1:0]}];
      pb_r <= mask_b[{idx_j_r[IdxW-1:0], row0[RowW-1:0], col0[ColW-1:0]}];
    end
  end

  logic hit;
  assign hit = rd_v_r && rd_in_r && (pa_r != PIX_EMPTY) && (pb_r != PIX_EMPTY);

  logic [12:0] occ_sel;
  assign occ_sel = (bi_r.bottom < bj_r.bottom) ? oi_r : oj_r;
  logic [13:0] trial;
  assign trial = {rem_r[12:0], num_r[16]} - {1'b0, ovl_r};
  // only in-mask pixels are counted, so counts never exceed 4096

  logic query_acc, bad_pair, isect, finish;
  assign query_acc = accept && (in_req_type == REQ_QUERY);
  assign bad_pair  = (in_first_index == in_second_index) ||
                     ({1'b0, in_first_index} >= 5'(Patterns)) ||
                     ({1'b0, in_second_index} >= 5'(Patterns));
  assign isect     = (ix_r >= ix_l) && (iy_b >= iy_t);
  assign finish    = ((state_r == ST_IDLE) && query_acc && bad_pair) ||
                     ((state_r == ST_BOX) && !isect) ||
                     ((state_r == ST_DIV) && (div_cnt_r == 5'd0));

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE:  if (query_acc && !bad_pair) state_nxt = ST_BOX;
      ST_BOX:   state_nxt = isect ? ST_GEOM : ST_IDLE;
      ST_GEOM:  state_nxt = ST_WALK;
      ST_WALK:  if (walk_last_r) state_nxt = ST_DRAIN;
      ST_DRAIN: state_nxt = ST_LOAD;
      ST_LOAD:  state_nxt = ST_DIV;
      ST_DIV:   if (div_cnt_r == 5'd0) state_nxt = ST_IDLE;
      default:  state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
      rd_v_r      <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= finish;
      rd_v_r      <= walk_rd;
      unique case (state_r)
        ST_IDLE: begin
          if (query_acc) begin
            idx_i_r <= qi;
            idx_j_r <= qj;
            inter_r <= 1'b0;
            quo_r   <= '0;
          end
        end
        ST_BOX: begin
          inter_r <= isect;
          xmin_r <= ux_l; xmax_r <= ux_r; ymax_r <= uy_b;
          x_r <= ux_l; y_r <= uy_t;
          walk_last_r <= (ux_l >= ux_r) && (uy_t >= uy_b);
        end
        ST_GEOM: ;
        ST_WALK: begin
          // row-major over the union: coordinates xmin..xmax, ymin..ymax
          if (x_r >= xmax_r) begin
            x_r <= xmin_r;
            y_r <= y_r + 7'd1;
          end else begin
            x_r <= x_r + 7'd1;
          end
          walk_last_r <= (x_r >= xmax_r) ? ((xmin_r >= xmax_r) && (y_r + 7'd1 >= ymax_r))
                                         : ((x_r + 7'd1 >= xmax_r) && (y_r >= ymax_r));
        end
        ST_DRAIN: ;  // last pixel lands in the counters
        ST_LOAD: begin
          // occ <= overlap keeps the quotient in 17 bits, so the top dividend
          // bits leave occ >> 1 as the partial remainder
          num_r     <= {occ_sel[0], 16'd0};
          rem_r     <= {2'b00, occ_sel[12:1]};
          div_cnt_r <= 5'd16;
        end
        ST_DIV: begin
          num_r <= {num_r[15:0], 1'b0};
          if (!trial[13]) rem_r <= trial;
          else            rem_r <= {rem_r[12:0], num_r[16]};
          if (div_cnt_r == 5'd0 && ovl_r == 13'd0) quo_r <= '0;
          else                                      quo_r <= {quo_r[15:0], !trial[13]};
          div_cnt_r <= div_cnt_r - 5'd1;
        end
        default: ;
      endcase
      if (state_r == ST_IDLE) begin
        ovl_r <= '0; oi_r <= '0; oj_r <= '0;
      end else if (hit) begin
        ovl_r <= ovl_r + 13'd1;
        if (pa_r == PIX_OCCLUDED) oi_r <= oi_r + 13'd1;
        if (pb_r == PIX_OCCLUDED) oj_r <= oj_r + 13'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (walk_rd) rd_in_r <= in_mask;
  end

  assign out_valid           = out_valid_r;
  assign out_score           = quo_r;
  assign out_overlap_count   = inter_r ? ovl_r : '0;
  assign out_occluded_count  = inter_r ? occ_sel : '0;
  assign out_boxes_intersect = inter_r;

  a_busy_on_query: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_WALK) |-> busy) else $error("walk without busy");
  a_score_bound: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_score <= 17'd65536)) else $error("score above one");
  a_occ_le_ovl: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_occluded_count <= out_overlap_count)) else $error("occluded above overlap");
  a_zero_disjoint: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_boxes_intersect) |-> (out_score == 17'd0)) else $error("score when disjoint");

endmodule
